// ===== rtl/core/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg
// Shared widths and the elaboration-time builders for the sigmoid and
// softplus lookup tables of the sigmoid cross-entropy core.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int unsigned DataW  = 16;            // Q4.12 operands
  localparam int unsigned TgtW   = 13;            // unsigned Q1.12 target
  localparam int unsigned SigW   = 13;            // sigmoid entry, 0..4096
  localparam int unsigned SpW    = 12;            // softplus entry, 0..2839
  localparam int unsigned EntryW = SigW + SpW;
  localparam int unsigned AccW   = 32;            // Q8.24 accumulation
  localparam int unsigned FracW  = 12;

  localparam logic [SigW-1:0] Q12One   = SigW'(4096);
  localparam logic [63:0]     Q30One   = 64'd1 << 30;
  localparam logic [AccW-1:0] RoundHalf = AccW'(2048);

  typedef enum logic {
    MODE_FWD = 1'b0,
    MODE_BWD = 1'b1
  } mode_e;

  // shift-subtract divider, only evaluated while building constants
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-c), c in Q3.30, result Q30: series on c/16, then four squarings
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] c);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = c >> 4;
    term = Q30One;
    sum  = Q30One;
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * y) >> 30, 64'(k));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int k = 0; k < 4; k++) begin
      sum = (sum * sum + (64'd1 << 29)) >> 30;
    end
    return sum;
  endfunction

  // {sigmoid, softplus} at the midpoint of bin i out of n
  function automatic logic [EntryW-1:0] table_entry(input logic [63:0] i,
                                                     input logic [63:0] n);
    logic [63:0] c;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] sig;
    logic [63:0] sp;
    c   = udiv64((2 * i + 64'd1) << 32, n);
    e   = exp_neg_q30(c);
    den = Q30One + e;
    z   = udiv64(e << 30, 2 * Q30One + e);
    z2  = (z * z) >> 30;
    p   = z;
    acc = '0;
    sig = udiv64((64'd1 << 42) + (den >> 1), den);
    // ln(1+e) = 2*atanh(e/(2+e))
    for (int k = 0; k < 20; k++) begin
      acc = acc + udiv64(p, 64'(2 * k + 1));
      p   = (p * z2) >> 30;
    end
    sp = (2 * acc + (64'd1 << 17)) >> 18;
    return {sig[SigW-1:0], sp[SpW-1:0]};
  endfunction

endpackage

// ===== rtl/core/sce_if.sv =====
// ----------------------------------------------------------------------------
// sce_in_if / sce_out_if
// Valid/ready channels carrying input and result words of the core.
// ----------------------------------------------------------------------------
interface sce_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [sce_pkg::DataW-1:0]    logit;
  logic        [sce_pkg::TgtW-1:0]     target;
  logic signed [sce_pkg::DataW-1:0]    upstream_grad;
  logic signed [sce_pkg::DataW-1:0]    prior_grad;

  modport source (output valid, mode, logit, target, upstream_grad, prior_grad,
                  input ready);
  modport sink   (input valid, mode, logit, target, upstream_grad, prior_grad,
                  output ready);
endinterface

interface sce_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sce_pkg::DataW-1:0]    result;
  logic                                saturated;

  modport source (output valid, result, saturated, input ready);
  modport sink   (input valid, result, saturated, output ready);
endinterface

// ===== rtl/core/sigmoid_cross_entropy_unit_core.sv =====
// ----------------------------------------------------------------------------
// sigmoid_cross_entropy_unit_core
// Element-wise binary cross entropy with logits: forward loss or backward
// gradient accumulate, table-based sigmoid/softplus, saturating Q4.12 output.
// ----------------------------------------------------------------------------
//  port    dir  handshake      word
//  in_i    in   valid/ready    mode, logit, target, upstream_grad, prior_grad
//  out_o   out  valid/ready    result, saturated
//
//  Four register stages: index, table read + x*t, (s-t)*g + forward sum, round/saturate.
//  Words pass v1_q..v4_q to out_o.valid; one word per cycle when not stalled.
//  Reset clears only the stage valid bits; the table is constant logic.
//  A stage advances when the one after it is empty or moving, so a stall
//  on out_o backs up stage by stage and bubbles are squeezed out.
// ----------------------------------------------------------------------------
module sigmoid_cross_entropy_unit_core #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sce_in_if.sink    in_i,
  sce_out_if.source out_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned AbsW  = sce_pkg::DataW + 1;
  localparam int unsigned ProdW = AbsW + IdxW + 1;
  localparam int unsigned WideW = ProdW - 15;
  localparam int unsigned XtW   = sce_pkg::DataW + sce_pkg::TgtW + 1;
  localparam int unsigned DiffW = sce_pkg::TgtW + 1;
  localparam int unsigned GpW   = DiffW + sce_pkg::DataW;
  localparam int unsigned RndW  = sce_pkg::AccW - sce_pkg::FracW;

  // constant table
  logic [sce_pkg::EntryW-1:0] rom [TABLE_ENTRIES];

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_rom
    localparam logic [sce_pkg::EntryW-1:0] Entry =
      sce_pkg::table_entry(64'(gi), 64'(TABLE_ENTRIES));
    assign rom[gi] = Entry;
  end

  // stage enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // ---------------- stage 1: table index ----------------
  logic signed [AbsW-1:0]  x_ext;
  logic        [AbsW-1:0]  abs_x;
  logic        [ProdW-1:0] idx_prod;
  logic        [WideW-1:0] idx_wide;
  logic        [IdxW-1:0]  idx_d;

  assign x_ext    = AbsW'(in_i.logit);
  assign abs_x    = in_i.logit[sce_pkg::DataW-1] ? AbsW'(-x_ext) : AbsW'(x_ext);
  assign idx_prod = ProdW'(abs_x) * ProdW'(TABLE_ENTRIES);
  assign idx_wide = idx_prod[ProdW-1:15];
  // |x| = 8 lands one past the end
  assign idx_d    = (idx_wide > WideW'(TABLE_ENTRIES - 1)) ? IdxW'(TABLE_ENTRIES - 1)
                                                           : idx_wide[IdxW-1:0];

  logic                              mode1_q;
  logic signed [sce_pkg::DataW-1:0]  x1_q, g1_q, p1_q;
  logic        [sce_pkg::TgtW-1:0]   t1_q;
  logic        [IdxW-1:0]            idx1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      mode1_q <= in_i.mode;
      x1_q    <= in_i.logit;
      t1_q    <= in_i.target;
      g1_q    <= in_i.upstream_grad;
      p1_q    <= in_i.prior_grad;
      idx1_q  <= idx_d;
    end
  end

  // ---------------- stage 2: table read, x*t ----------------
  logic signed [XtW-1:0] xt_d;
  assign xt_d = XtW'(x1_q) * $signed(XtW'(t1_q));

  logic                              mode2_q;
  logic signed [sce_pkg::DataW-1:0]  x2_q, g2_q, p2_q;
  logic        [sce_pkg::TgtW-1:0]   t2_q;
  logic        [sce_pkg::SigW-1:0]   sig2_q;
  logic        [sce_pkg::SpW-1:0]    sp2_q;
  logic signed [XtW-1:0]             xt2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      mode2_q <= mode1_q;
      x2_q    <= x1_q;
      t2_q    <= t1_q;
      g2_q    <= g1_q;
      p2_q    <= p1_q;
      {sig2_q, sp2_q} <= rom[idx1_q];
      xt2_q   <= xt_d;
    end
  end

  // ---------------- stage 3: (s-t)*g, forward sum ----------------
  logic        [sce_pkg::SigW-1:0]  s_d;
  logic signed [DiffW-1:0]          diff_d;
  logic signed [GpW-1:0]            gp_d;
  logic signed [sce_pkg::AccW-1:0]  pos_d;
  logic signed [sce_pkg::AccW-1:0]  fwd_d;

  // sigmoid(x) = 1 - sigmoid(|x|) for negative x
  assign s_d    = x2_q[sce_pkg::DataW-1] ? (sce_pkg::Q12One - sig2_q) : sig2_q;
  assign diff_d = $signed(DiffW'(s_d)) - $signed(DiffW'(t2_q));
  assign gp_d   = GpW'(diff_d) * GpW'(g2_q);
  assign pos_d  = x2_q[sce_pkg::DataW-1] ? '0 : sce_pkg::AccW'(x2_q);
  assign fwd_d  = (pos_d <<< sce_pkg::FracW) - sce_pkg::AccW'(xt2_q)
                + $signed(sce_pkg::AccW'(sp2_q) << sce_pkg::FracW);

  logic                              mode3_q;
  logic signed [sce_pkg::DataW-1:0]  p3_q;
  logic signed [GpW-1:0]             gp3_q;
  logic signed [sce_pkg::AccW-1:0]   fwd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      mode3_q <= mode2_q;
      p3_q    <= p2_q;
      gp3_q   <= gp_d;
      fwd3_q  <= fwd_d;
    end
  end

  // ---------------- stage 4: round half up, saturate ----------------
  logic signed [sce_pkg::AccW-1:0]  sum_d;
  logic signed [sce_pkg::AccW-1:0]  rnd_d;
  logic signed [RndW-1:0]           r_d;
  logic signed [sce_pkg::DataW-1:0] res_d;
  logic                             sat_d;

  always_comb begin
    if (sce_pkg::mode_e'(mode3_q) == sce_pkg::MODE_BWD) begin
      sum_d = (sce_pkg::AccW'(p3_q) <<< sce_pkg::FracW) + sce_pkg::AccW'(gp3_q);
    end else begin
      sum_d = fwd3_q;
    end
    rnd_d = sum_d + $signed(sce_pkg::RoundHalf);
    r_d   = rnd_d[sce_pkg::AccW-1:sce_pkg::FracW];
    if (r_d > RndW'(32767)) begin
      res_d = 16'sh7FFF;
      sat_d = 1'b1;
    end else if (r_d < -RndW'(32768)) begin
      res_d = -16'sh8000;
      sat_d = 1'b1;
    end else begin
      res_d = r_d[sce_pkg::DataW-1:0];
      sat_d = 1'b0;
    end
  end

  logic signed [sce_pkg::DataW-1:0] res4_q;
  logic                             sat4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      res4_q <= res_d;
      sat4_q <= sat_d;
    end
  end

  assign out_o.valid     = v4_q;
  assign out_o.result    = res4_q;
  assign out_o.saturated = sat4_q;

endmodule

// ===== tb/sv/sigmoid_cross_entropy_unit_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sigmoid_cross_entropy_unit_core_tb
// Streams elements through the cross-entropy core in both modes: a directed
// table of corner words, then random words. Every result word is compared
// against a known reply or a local fixed-point model of the loss and
// gradient, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module sigmoid_cross_entropy_unit_core_tb;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned NumRandom    = 1500;
  localparam int unsigned MaxIdle      = 16;

  localparam sce_pkg::mode_e Fwd = sce_pkg::MODE_FWD;
  localparam sce_pkg::mode_e Bwd = sce_pkg::MODE_BWD;

  typedef struct packed {
    sce_pkg::mode_e                   mode;
    logic signed [sce_pkg::DataW-1:0] logit;
    logic        [sce_pkg::TgtW-1:0]  target;
    logic signed [sce_pkg::DataW-1:0] upstream_grad;
    logic signed [sce_pkg::DataW-1:0] prior_grad;
  } elem_word_t;

  typedef struct packed {
    logic signed [sce_pkg::DataW-1:0] result;
    logic                             saturated;
  } loss_word_t;

  typedef struct packed {
    elem_word_t  elem;
    logic        known;   // reply below is the expected word, else model it
    loss_word_t  reply;
  } corner_row_t;

  localparam int unsigned NumCorners = 23;

  // known rows: zero upstream passes prior through; huge terms clamp
  localparam corner_row_t CornerRows [NumCorners] = '{
    '{'{Fwd, 16'sd0,     13'd0,    16'sd0,     16'sd0    }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Fwd, 16'sd32767, 13'd0,    16'sd0,     16'sd0    }, 1'b1, '{16'sd32767, 1'b1}},
    '{'{Fwd, 16'sh8000,  13'd0,    16'sd0,     16'sd0    }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Fwd, 16'sd32767, 13'd4096, 16'sd0,     16'sd0    }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Fwd, 16'sh8000,  13'd4096, 16'sd0,     16'sd0    }, 1'b1, '{16'sd32767, 1'b1}},
    '{'{Fwd, 16'sd32767, 13'd8191, 16'sd0,     16'sd0    }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Fwd, 16'sh8000,  13'd8191, 16'sd0,     16'sd0    }, 1'b1, '{16'sd32767, 1'b1}},
    '{'{Fwd, 16'sd4096,  13'd2048, 16'sh8000,  16'sd32767}, 1'b0, '{16'sd0,     1'b0}},
    '{'{Fwd, 16'shFFFF,  13'd4096, 16'sd0,     16'sd0    }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Fwd, 16'sd128,   13'd0,    16'sd0,     16'sd0    }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Fwd, 16'sd127,   13'd0,    16'sd0,     16'sd0    }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Bwd, 16'sd0,     13'd0,    16'sd0,     16'sd0    }, 1'b1, '{16'sd0,     1'b0}},
    '{'{Bwd, 16'sd1234,  13'd100,  16'sd0,     16'sd32767}, 1'b1, '{16'sd32767, 1'b0}},
    '{'{Bwd, 16'sh8000,  13'd0,    16'sd0,     16'sh8000 }, 1'b1, '{16'sh8000,  1'b0}},
    '{'{Bwd, 16'sd32767, 13'd0,    16'sd32767, 16'sd32767}, 1'b1, '{16'sd32767, 1'b1}},
    '{'{Bwd, 16'sd32767, 13'd8191, 16'sd32767, 16'sh8000 }, 1'b1, '{16'sh8000,  1'b1}},
    '{'{Bwd, 16'sh8000,  13'd0,    16'sh8000,  16'sh8000 }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Bwd, 16'sd0,     13'd4096, 16'sd4096,  16'sd0    }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Bwd, 16'shFFFF,  13'd0,    16'sd4096,  16'sd0    }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Bwd, 16'sd8191,  13'd2048, 16'shF000,  16'sd100  }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Bwd, 16'sd8192,  13'd2048, 16'shF000,  16'sd100  }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Bwd, 16'shFFEB,  13'd7,    16'sd32767, 16'sh8000 }, 1'b0, '{16'sd0,     1'b0}},
    '{'{Bwd, 16'sd2,     13'd1,    16'sd2048,  16'sd0    }, 1'b0, '{16'sd0,     1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  sce_in_if  in_if ();
  sce_out_if out_if ();

  sigmoid_cross_entropy_unit_core #(
    .TABLE_ENTRIES(TableEntries)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  loss_word_t  pending_losses [$];
  int unsigned mismatches = 0;
  bit          in_steady  = 1'b0;   // no input gaps while set
  bit          out_steady = 1'b0;   // no output stalls while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exp(-c), c in Q3.30, Q30 result: series on c/16, then square four times
  function automatic longint unsigned exp_neg_q30(input longint unsigned c);
    longint unsigned y;
    longint unsigned term;
    longint unsigned sum;
    y    = c >> 4;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * y) >> 30) / longint'(k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int k = 0; k < 4; k++) begin
      sum = (sum * sum + (64'd1 << 29)) >> 30;
    end
    return sum;
  endfunction

  // sigmoid and ln(1+exp(-a)) at the midpoint of bin idx, both Q4.12
  function automatic void bin_values(input int unsigned idx, output longint sig,
                                     output longint softplus);
    longint unsigned c;
    longint unsigned e;
    longint unsigned den;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned pw;
    longint unsigned acc;
    c   = (longint'(2 * idx + 1) << 32) / longint'(TableEntries);
    e   = exp_neg_q30(c);
    den = (64'd1 << 30) + e;
    z   = (e << 30) / ((64'd1 << 31) + e);
    z2  = (z * z) >> 30;
    pw  = z;
    acc = 0;
    for (int k = 0; k < 20; k++) begin
      acc = acc + pw / longint'(2 * k + 1);
      pw  = (pw * z2) >> 30;
    end
    sig      = longint'(((64'd1 << 42) + den / 2) / den);
    softplus = longint'((2 * acc + (64'd1 << 17)) >> 18);
  endfunction

  function automatic loss_word_t bce_result(input elem_word_t w);
    longint      x;
    longint      t;
    longint      g;
    longint      p;
    longint      sig;
    longint      softplus;
    longint      s;
    longint      acc;
    longint      r;
    int unsigned idx;
    loss_word_t  res;
    x   = longint'(w.logit);
    t   = longint'(w.target);
    g   = longint'(w.upstream_grad);
    p   = longint'(w.prior_grad);
    idx = int'(((x < 0) ? -x : x) * TableEntries) >> 15;
    if (idx > TableEntries - 1) begin
      idx = TableEntries - 1;
    end
    bin_values(idx, sig, softplus);
    if (w.mode == sce_pkg::MODE_FWD) begin
      acc = ((x > 0) ? x : 0) * 4096 - x * t + softplus * 4096;
    end else begin
      s   = (x >= 0) ? sig : 4096 - sig;
      acc = p * 4096 + (s - t) * g;
    end
    r = (acc + 2048) >>> 12;   // round half up to Q4.12
    res.saturated = 1'b1;
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end else begin
      res.saturated = 1'b0;
    end
    res.result = sce_pkg::DataW'(r);
    return res;
  endfunction

  function automatic logic [sce_pkg::DataW-1:0] random_operand();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return sce_pkg::DataW'($urandom_range(0, 16384)) - 16'd8192;
      default: return sce_pkg::DataW'($urandom());
    endcase
  endfunction

  function automatic elem_word_t random_elem();
    elem_word_t w;
    w.mode          = sce_pkg::mode_e'($urandom_range(0, 1));
    w.logit         = random_operand();
    w.upstream_grad = random_operand();
    w.prior_grad    = random_operand();
    case ($urandom_range(0, 9))
      0:       w.target = ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'd0;
      1, 2:    w.target = sce_pkg::TgtW'($urandom());   // above one as well
      default: w.target = sce_pkg::TgtW'($urandom_range(0, 4096));
    endcase
    return w;
  endfunction

  task automatic send_elem(input elem_word_t w, input bit known, input loss_word_t reply);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, MaxIdle);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid         <= 1'b1;
    in_if.mode          <= w.mode;
    in_if.logit         <= w.logit;
    in_if.target        <= w.target;
    in_if.upstream_grad <= w.upstream_grad;
    in_if.prior_grad    <= w.prior_grad;
    do @(posedge clk); while (!in_if.ready);
    pending_losses.push_back(known ? reply : bce_result(w));
    if ($urandom_range(0, 99) == 0) begin
      in_steady = !in_steady;
    end
  endtask

  // result side: random stall before each word while out_steady is clear
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, MaxIdle);
      repeat (stall) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      if ($urandom_range(0, 99) == 0) begin
        out_steady = !out_steady;
      end
    end
  end

  always @(posedge clk) begin
    loss_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_losses.size() == 0) begin
        $error("result word with none pending: result %0d saturated %0b",
               out_if.result, out_if.saturated);
        mismatches++;
      end else begin
        want = pending_losses.pop_front();
        if (out_if.result !== want.result) begin
          $error("result: expected %0d, got %0d", want.result, out_if.result);
          mismatches++;
        end
        if (out_if.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_if.saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.mode          = sce_pkg::MODE_FWD;
    in_if.logit         = '0;
    in_if.target        = '0;
    in_if.upstream_grad = '0;
    in_if.prior_grad    = '0;
    rst_n               = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumCorners; i++) begin
      send_elem(CornerRows[i].elem, CornerRows[i].known, CornerRows[i].reply);
    end
    for (int i = 0; i < NumRandom; i++) begin
      send_elem(random_elem(), 1'b0, '0);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (pending_losses.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
